>>> sv/mac_address_filter_lists_top_assert.svh
// Assertion macros for the MAC address filter lists block.
`ifndef MAC_ADDRESS_FILTER_LISTS_TOP_ASSERT_SVH
`define MAC_ADDRESS_FILTER_LISTS_TOP_ASSERT_SVH

`ifndef SYNTH

`define MAFL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mafl assertion failed");

`define MAFL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mafl assertion failed");

`else

`define MAFL_ASSERT_NOW(lbl, ante, cons)

`define MAFL_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> sv/mafl_pkg.sv
package mafl_pkg;

  localparam int MAC_W            = 48;
  localparam int STATUS_W         = 2;
  localparam int LIST_DEPTH_DEF   = 64;
  localparam int OUT_TDATA_W      = 8;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_LOOKUP = 1'b1
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE = 2'd0,
    STATUS_DUP  = 2'd1,
    STATUS_FULL = 2'd2
  } status_e;

endpackage

>>> sv/mac_address_filter_lists_top.sv
// MAC address filter lists: a block list and an allow list of 48-bit station
// addresses, each holding up to LIST_DEPTH entries in one shared RAM.
// Input stream: tdata carries the address, tuser carries the action (bit 0,
// insert or look up) and the list select (bit 1, block or allow list).
// Output stream: one transfer per input transfer, tdata bit 0 is hit and
// bits 2:1 are status (done, duplicate insert, insert dropped on full list).
// Each item scans the stored entries of the selected list one per cycle
// through the RAM read port and a single 48-bit comparator. The next item
// can be taken the cycle after the result is loaded. A new item is taken
// only when the scan engine is idle; the result register lets the next
// item be taken while a result still waits. If the receiver stalls, a
// finished scan waits with its result until the output register frees up.
// Reset empties both lists by clearing their entry counts; the RAM itself is
// not cleared, since only entries below the count are ever compared.
module mac_address_filter_lists_top import mafl_pkg::*; #(
  parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [MAC_W-1:0]       s_axis_tdata_i,   // [47:0] mac_address
  input  logic [1:0]             s_axis_tuser_i,   // [0] action, [1] list_select
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o    // [0] hit, [2:1] status, [7:3] zero
);

  localparam int IdxW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CntW = $clog2(LIST_DEPTH + 1);
  localparam int AddrW = IdxW + 1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [CntW-1:0]   cnt_q [2];
  logic [CntW-1:0]   cur_cnt;
  logic [CntW-1:0]   idx_q, idx_d;
  logic              pend_q, pend_d;
  logic              found_q, found_d;
  action_e           action_q;
  logic              sel_q;
  logic [MAC_W-1:0]  addr_q;

  logic              out_valid_q;
  logic              out_hit_q;
  status_e           out_status_q;
  status_e           status_d;
  logic              out_free;
  logic              accept;
  logic              issue;
  logic              finish;
  logic              ram_we;
  logic [MAC_W-1:0]  ram_rdata;

  assign cur_cnt         = cnt_q[sel_q];
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign issue           = (state_q == ST_SCAN) && (idx_q < cur_cnt);
  assign finish          = (state_q == ST_DONE) && out_free;

  always_comb begin
    status_d = STATUS_DONE;
    if (action_q == ACT_INSERT) begin
      if (found_q) begin
        status_d = STATUS_DUP;
      end else if (cur_cnt >= CntW'(LIST_DEPTH)) begin
        status_d = STATUS_FULL;
      end
    end
  end

  assign ram_we = finish && (action_q == ACT_INSERT) && (status_d == STATUS_DONE);

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    pend_d  = pend_q;
    found_d = found_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_SCAN;
          idx_d   = '0;
          pend_d  = 1'b0;
          found_d = 1'b0;
        end
      end
      ST_SCAN: begin
        // The read issued last cycle returns now and meets the comparator.
        if (pend_q && (ram_rdata == addr_q)) begin
          found_d = 1'b1;
        end
        pend_d = issue;
        if (issue) begin
          idx_d = idx_q + 1'b1;
        end else if (!pend_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      found_q     <= 1'b0;
      cnt_q[0]    <= '0;
      cnt_q[1]    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      pend_q  <= pend_d;
      found_q <= found_d;
      if (ram_we) begin
        cnt_q[sel_q] <= cur_cnt + 1'b1;
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      action_q <= action_e'(s_axis_tuser_i[0]);
      sel_q    <= s_axis_tuser_i[1];
      addr_q   <= s_axis_tdata_i;
    end
    if (finish) begin
      out_hit_q    <= found_q;
      out_status_q <= status_d;
    end
  end

  mafl_ram #(
    .ADDR_W (AddrW),
    .DATA_W (MAC_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i ({sel_q, cur_cnt[IdxW-1:0]}),
    .wdata_i (addr_q),
    .re_i    (issue),
    .raddr_i ({sel_q, idx_q[IdxW-1:0]}),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OUT_TDATA_W - STATUS_W - 1){1'b0}}, out_status_q, out_hit_q};

`include "mac_address_filter_lists_top_assert.svh"

  `MAFL_ASSERT_NOW(a_cnt_bounded, 1'b1, (cnt_q[0] <= CntW'(LIST_DEPTH)) && (cnt_q[1] <= CntW'(LIST_DEPTH)))
  `MAFL_ASSERT_NOW(a_full_only_at_depth, (state_q == ST_DONE) && (status_d == STATUS_FULL), cur_cnt == CntW'(LIST_DEPTH))
  `MAFL_ASSERT_NEXT(a_finish_loads_out, finish, m_axis_tvalid_o && (state_q == ST_IDLE))
  `MAFL_ASSERT_NOW(a_no_write_while_scanning, state_q != ST_DONE, !ram_we)

endmodule

>>> sv/mafl_ram.sv
module mafl_ram import mafl_pkg::*; #(
  parameter int ADDR_W = 7,
  parameter int DATA_W = MAC_W
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  localparam int Depth = 1 << ADDR_W;

  logic [DATA_W-1:0] mem_q [Depth];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> test/mac_address_filter_lists_top_test.sv
module mac_address_filter_lists_top_test;
  import mafl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH   = LIST_DEPTH_DEF;
  localparam int POOL_SZ = 256;

  typedef struct packed {
    logic    hit;
    status_e status;
  } filter_verdict_t;

  logic                   clk_i = 1'b0;
  logic                   rst_n;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [MAC_W-1:0]       s_tdata;   // [47:0] mac_address
  logic [1:0]             s_tuser;   // [0] action, [1] list_select
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;   // [0] hit, [2:1] status, [7:3] zero

  // Shadow copy of both address lists; index 0 is the block list, 1 the allow list.
  logic [MAC_W-1:0] list_tab[2][DEPTH];
  int               list_cnt[2];

  filter_verdict_t  verdict_q[$];
  logic [MAC_W-1:0] seen_macs[$];
  int               fail_count   = 0;
  bit               tx_idle_en   = 1'b1;
  bit               rx_idle_en   = 1'b1;
  int               rx_hold_req  = 0;
  int               rx_hold_left = 0;

  mac_address_filter_lists_top #(
    .LIST_DEPTH(DEPTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("FAIL mac_address_filter_lists_top");
    $finish;
  end

  // Looks the address up in the selected list and applies an insert.
  function automatic filter_verdict_t filter_lookup_insert(action_e act, logic sel,
                                                           logic [MAC_W-1:0] mac);
    filter_verdict_t v;
    int              idx;
    idx       = int'(sel);
    v.hit     = 1'b0;
    v.status  = STATUS_DONE;
    for (int i = 0; i < list_cnt[idx]; i++) begin
      if (list_tab[idx][i] == mac) v.hit = 1'b1;
    end
    if (act == ACT_INSERT) begin
      if (v.hit) begin
        v.status = STATUS_DUP;
      end else if (list_cnt[idx] >= DEPTH) begin
        v.status = STATUS_FULL;
      end else begin
        list_tab[idx][list_cnt[idx]] = mac;
        list_cnt[idx]++;
      end
    end
    return v;
  endfunction

  // Receiver: random stalls, plus a long hold-off counted here on request.
  always @(posedge clk_i) begin
    if (rx_hold_req > 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req  = 0;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_tready <= 1'b0;
    end else if (!rx_idle_en) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= 25);
    end
  end

  always @(posedge clk_i) begin : check_results
    filter_verdict_t want;
    if (rst_n && m_tvalid && m_tready) begin
      if (verdict_q.size() == 0) begin
        $error("result transfer with no expectation pending: tdata=%0h", m_tdata);
        fail_count++;
      end else begin
        want = verdict_q.pop_front();
        if (m_tdata[0] !== want.hit) begin
          $error("hit mismatch: expected %0d, actual %0d", want.hit, m_tdata[0]);
          fail_count++;
        end
        if (m_tdata[2:1] !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, m_tdata[2:1]);
          fail_count++;
        end
        if (m_tdata[OUT_TDATA_W-1:3] !== '0) begin
          $error("pad mismatch: expected 0, actual %0h", m_tdata[OUT_TDATA_W-1:3]);
          fail_count++;
        end
      end
    end
  end

  // Offers one item and records its verdict once the transfer is taken.
  // Valid stays high afterwards so back-to-back items need no extra edge.
  task automatic send_filter_item(action_e act, logic sel, logic [MAC_W-1:0] mac);
    int gap;
    gap = 0;
    if (tx_idle_en) begin
      while ($urandom_range(99) < 25) gap++;
    end
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= mac;
    s_tuser  <= {sel, act};
    do @(posedge clk_i); while (!s_tready);
    verdict_q.push_back(filter_lookup_insert(act, sel, mac));
  endtask

  task automatic wait_results_drained();
    s_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [MAC_W-1:0] random_mac();
    return {16'($urandom()), 32'($urandom())};
  endfunction

  task automatic test_empty_lists();
    send_filter_item(ACT_LOOKUP, 1'b0, '0);
    send_filter_item(ACT_LOOKUP, 1'b1, '1);
    wait_results_drained();
  endtask

  task automatic test_insert_and_lookup();
    send_filter_item(ACT_INSERT, 1'b0, '0);
    send_filter_item(ACT_INSERT, 1'b0, '1);
    send_filter_item(ACT_INSERT, 1'b0, '0);
    send_filter_item(ACT_LOOKUP, 1'b0, '1);
    // Differs from a stored address only in the top bit.
    send_filter_item(ACT_LOOKUP, 1'b0, 48'h7FFF_FFFF_FFFF);
    send_filter_item(ACT_LOOKUP, 1'b1, '0);
    send_filter_item(ACT_INSERT, 1'b1, '0);
    send_filter_item(ACT_INSERT, 1'b1, 48'hA5A5_A5A5_A5A5);
    send_filter_item(ACT_LOOKUP, 1'b1, 48'h5A5A_5A5A_5A5A);
    send_filter_item(ACT_INSERT, 1'b1, 48'hA5A5_A5A5_A5A5);
    send_filter_item(ACT_LOOKUP, 1'b1, 48'hA5A5_A5A5_A5A5);
    send_filter_item(ACT_LOOKUP, 1'b0, '0);
    send_filter_item(ACT_LOOKUP, 1'b0, 48'hA5A5_A5A5_A5A5);
    wait_results_drained();
  endtask

  // The receiver stops for a long time while items keep coming, so the
  // block backs up and drops its tready.
  task automatic test_back_pressure();
    rx_hold_req = 400;
    for (int i = 0; i < 16; i++) begin
      send_filter_item(action_e'($urandom_range(1)), 1'($urandom_range(1)), random_mac());
    end
    wait_results_drained();
  endtask

  // About half reuse addresses already seen, so duplicates and hits are common; the
  // rest are fresh addresses and single-bit neighbors of stored ones.
  task automatic send_random_item();
    int               pick;
    action_e          act;
    logic             sel;
    logic [MAC_W-1:0] mac;
    pick = $urandom_range(99);
    act  = ($urandom_range(99) < 45) ? ACT_INSERT : ACT_LOOKUP;
    sel  = 1'($urandom_range(1));
    if (seen_macs.size() == 0 || pick < 35) begin
      mac = random_mac();
    end else if (pick < 85) begin
      mac = seen_macs[$urandom_range(seen_macs.size() - 1)];
    end else begin
      mac = seen_macs[$urandom_range(seen_macs.size() - 1)]
            ^ (48'd1 << $urandom_range(MAC_W - 1));
    end
    if (act == ACT_INSERT && seen_macs.size() < POOL_SZ) seen_macs.push_back(mac);
    send_filter_item(act, sel, mac);
  endtask

  task automatic test_random_traffic();
    repeat (400) send_random_item();
    // Sender pauses here until every result has come back.
    wait_results_drained();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    repeat (250) send_random_item();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    repeat (450) send_random_item();
    wait_results_drained();
  endtask

  task automatic test_full_list();
    logic [MAC_W-1:0] mac;
    for (int sel = 0; sel < 2; sel++) begin
      while (list_cnt[sel] < DEPTH) send_filter_item(ACT_INSERT, 1'(sel), random_mac());
      send_filter_item(ACT_INSERT, 1'(sel), random_mac());
      mac = list_tab[sel][DEPTH - 1];
      send_filter_item(ACT_INSERT, 1'(sel), mac);
      send_filter_item(ACT_LOOKUP, 1'(sel), mac);
      send_filter_item(ACT_LOOKUP, 1'(sel), list_tab[sel][0]);
    end
    wait_results_drained();
  endtask

  initial begin
    list_cnt[0] = 0;
    list_cnt[1] = 0;
    rst_n    <= 1'b0;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= '0;
    repeat (5) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);
    test_empty_lists();
    test_insert_and_lookup();
    test_back_pressure();
    test_random_traffic();
    test_full_list();
    repeat (2 * DEPTH + 16) @(posedge clk_i);
    if (fail_count == 0 && verdict_q.size() == 0) begin
      $display("PASS mac_address_filter_lists_top");
    end else begin
      $display("FAIL mac_address_filter_lists_top");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/mafl_pkg.sv
sv/mafl_ram.sv
sv/mac_address_filter_lists_top.sv
test/mac_address_filter_lists_top_test.sv
